// ===== rtl/core/dqpi_pkg.sv =====
// ----------------------------------------------------------------------------
// dqpi_pkg
// Shared types, constants and fixed-point helpers for the dq current PI block.
// ----------------------------------------------------------------------------
package dqpi_pkg;

  // Fixed-point format and widths
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned GAIN_W     = 31;
  localparam int unsigned PROD_W     = DATA_W + GAIN_W;
  localparam int unsigned NUM_STAGES = 5;
  localparam int unsigned IDX_W      = 3;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_TARGET_LIMIT = 3'd0,
    REG_PROP_GAIN    = 3'd1,
    REG_INTEG_GAIN   = 3'd2,
    REG_INTEG_LIMIT  = 3'd3,
    REG_OUT_LIMIT    = 3'd4
  } reg_idx_e;

  // Register file contents
  typedef struct packed {
    logic [GAIN_W-1:0] target_limit;
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] integ_limit;
    logic [GAIN_W-1:0] out_limit;
  } cfg_t;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic err_en;
    logic prod_en;
    logic term_en;
    logic integ_en;
    logic out_en;
  } pipe_en_t;

  // Saturate a 33-bit signed sum to 32 bits
  function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Symmetric clamp to +/-lim
  function automatic logic signed [DATA_W-1:0] clamp_sym(input logic signed [DATA_W-1:0] v,
                                                         input logic [GAIN_W-1:0] lim);
    logic signed [DATA_W:0]   vx;
    logic signed [DATA_W:0]   lp;
    logic signed [DATA_W:0]   ln;
    logic signed [DATA_W-1:0] r;
    vx = {v[DATA_W-1], v};
    lp = {2'b00, lim};
    ln = -lp;
    if (vx > lp) begin
      r = lp[DATA_W-1:0];
    end else if (vx < ln) begin
      r = ln[DATA_W-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Arithmetic right shift by the fraction width, then saturate to 32 bits
  function automatic logic signed [DATA_W-1:0] shift_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] sh;
    logic signed [DATA_W-1:0] r;
    sh = p >>> FRAC_BITS;
    if (sh[PROD_W-1:DATA_W-1] == {(PROD_W-DATA_W+1){sh[DATA_W-1]}}) begin
      r = sh[DATA_W-1:0];
    end else begin
      r = sh[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/dqpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// dqpi_ctrl
// Valid tracking and per-stage ready chain for the lane pipeline; the last
// stage is the shared output register.
// ----------------------------------------------------------------------------
module dqpi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dqpi_pkg::pipe_en_t en_o
);

  logic [dqpi_pkg::NUM_STAGES-1:0] valid_q;
  logic [dqpi_pkg::NUM_STAGES-1:0] valid_d;
  logic [dqpi_pkg::NUM_STAGES-1:0] rdy;
  logic [dqpi_pkg::NUM_STAGES-1:0] load;

  // Stage may take a new item when empty or when its item moves on
  always_comb begin
    rdy[dqpi_pkg::NUM_STAGES-1] = !valid_q[dqpi_pkg::NUM_STAGES-1] || out_ready_i;
    for (int k = dqpi_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  // Load enables and next valid bits
  always_comb begin
    load[0]    = in_valid_i && rdy[0];
    valid_d[0] = rdy[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < dqpi_pkg::NUM_STAGES; k++) begin
      load[k]    = valid_q[k-1] && rdy[k];
      valid_d[k] = rdy[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o      = rdy[0];
  assign out_valid_o     = valid_q[dqpi_pkg::NUM_STAGES-1];
  assign en_o.err_en     = load[0];
  assign en_o.prod_en    = load[1];
  assign en_o.term_en    = load[2];
  assign en_o.integ_en   = load[3];
  assign en_o.out_en     = load[4];

endmodule

// ===== rtl/core/dqpi_lane.sv =====
// ----------------------------------------------------------------------------
// dqpi_lane
// One axis of the PI regulator: target clamp and error, gain multiplies,
// shift and saturate, then the integral update with conditional integration.
// ----------------------------------------------------------------------------
module dqpi_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dqpi_pkg::pipe_en_t                  en_i,
  input  dqpi_pkg::cfg_t                      cfg_i,
  input  logic signed [dqpi_pkg::DATA_W-1:0]  target_i,
  input  logic signed [dqpi_pkg::DATA_W-1:0]  measured_i,
  output logic signed [dqpi_pkg::DATA_W-1:0]  pterm_o,
  output logic signed [dqpi_pkg::DATA_W-1:0]  acc_o
);

  localparam int unsigned W = dqpi_pkg::DATA_W;

  // Stage 1: clamp target, saturated error
  logic signed [W-1:0] tgt;
  logic signed [W:0]   diff;
  logic signed [W-1:0] err1_q;

  assign tgt  = dqpi_pkg::clamp_sym(target_i, cfg_i.target_limit);
  assign diff = {tgt[W-1], tgt} - {measured_i[W-1], measured_i};

  always_ff @(posedge clk_i) begin
    if (en_i.err_en) begin
      err1_q <= dqpi_pkg::sat33(diff);
    end
  end

  // Stage 2: gain products
  logic signed [2*W-1:0]                 pprod;
  logic signed [2*W-1:0]                 iprod;
  logic signed [dqpi_pkg::PROD_W-1:0]    pprod2_q;
  logic signed [dqpi_pkg::PROD_W-1:0]    iprod2_q;
  logic signed [W-1:0]                   err2_q;

  assign pprod = $signed({1'b0, cfg_i.prop_gain}) * err1_q;
  assign iprod = $signed({1'b0, cfg_i.integ_gain}) * err1_q;

  always_ff @(posedge clk_i) begin
    if (en_i.prod_en) begin
      pprod2_q <= pprod[dqpi_pkg::PROD_W-1:0];
      iprod2_q <= iprod[dqpi_pkg::PROD_W-1:0];
      err2_q   <= err1_q;
    end
  end

  // Stage 3: truncate and saturate the products
  logic signed [W-1:0] pterm3_q;
  logic signed [W-1:0] iterm3_q;
  logic signed [W-1:0] err3_q;

  always_ff @(posedge clk_i) begin
    if (en_i.term_en) begin
      pterm3_q <= dqpi_pkg::shift_sat(pprod2_q);
      iterm3_q <= dqpi_pkg::shift_sat(iprod2_q);
      err3_q   <= err2_q;
    end
  end

  // Stage 4: integral update, rollback when pushing deeper into saturation
  logic signed [W-1:0] integ_q;
  logic signed [W-1:0] sum1;
  logic signed [W-1:0] trial;
  logic signed [W:0]   trial_x;
  logic signed [W:0]   olim;
  logic                err_pos;
  logic                err_neg;
  logic                hold;
  logic signed [W-1:0] acc_pre;
  logic signed [W-1:0] acc_new;
  logic signed [W-1:0] pterm4_q;
  logic signed [W-1:0] acc4_q;

  always_comb begin
    sum1    = dqpi_pkg::sat33({integ_q[W-1], integ_q} + {iterm3_q[W-1], iterm3_q});
    trial   = dqpi_pkg::sat33({pterm3_q[W-1], pterm3_q} + {sum1[W-1], sum1});
    trial_x = {trial[W-1], trial};
    olim    = {2'b00, cfg_i.out_limit};
    err_pos = !err3_q[W-1] && (err3_q != '0);
    err_neg = err3_q[W-1];
    hold    = (trial_x >= olim && err_pos) || (trial_x <= -olim && err_neg);
    acc_pre = hold ? integ_q : sum1;
    acc_new = dqpi_pkg::clamp_sym(acc_pre, cfg_i.integ_limit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (en_i.integ_en) begin
      integ_q <= acc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pterm4_q <= '0;
      acc4_q   <= '0;
    end else if (en_i.integ_en) begin
      pterm4_q <= pterm3_q;
      acc4_q   <= acc_new;
    end
  end

  assign pterm_o = pterm4_q;
  assign acc_o   = acc4_q;

endmodule

// ===== rtl/core/dq_current_pi_antiwindup.sv =====
// ----------------------------------------------------------------------------
// dq_current_pi_antiwindup
// Stages: error, products, terms, integral, output register; one item per cycle
// unless the output stalls. The integral loop closes in one stage per lane.
// Reset: asynchronous, active low; clears valid bits, config and integrals.
// Two matched PI lanes (q, d) merge into one output register.
// ----------------------------------------------------------------------------
module dq_current_pi_antiwindup (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream: tdata = q_target, d_target, q_measured, d_measured (low first)
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [4*dqpi_pkg::DATA_W-1:0]      s_axis_tdata_i,
  // Output stream: tdata = q_voltage, d_voltage (low first)
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [2*dqpi_pkg::DATA_W-1:0]      m_axis_tdata_o,
  // Configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dqpi_pkg::IDX_W-1:0]         cfg_index_i,
  input  logic [dqpi_pkg::GAIN_W-1:0]        cfg_data_i
);

  localparam int unsigned W = dqpi_pkg::DATA_W;

  // Configuration registers
  dqpi_pkg::cfg_t cfg_q;
  dqpi_pkg::cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (dqpi_pkg::reg_idx_e'(cfg_index_i))
        dqpi_pkg::REG_TARGET_LIMIT: cfg_d.target_limit = cfg_data_i;
        dqpi_pkg::REG_PROP_GAIN:    cfg_d.prop_gain    = cfg_data_i;
        dqpi_pkg::REG_INTEG_GAIN:   cfg_d.integ_gain   = cfg_data_i;
        dqpi_pkg::REG_INTEG_LIMIT:  cfg_d.integ_limit  = cfg_data_i;
        dqpi_pkg::REG_OUT_LIMIT:    cfg_d.out_limit    = cfg_data_i;
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pipeline control
  dqpi_pkg::pipe_en_t en;

  dqpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .en_o        (en)
  );

  // Lanes
  logic signed [W-1:0] q_pterm;
  logic signed [W-1:0] q_acc;
  logic signed [W-1:0] d_pterm;
  logic signed [W-1:0] d_acc;

  dqpi_lane u_lane_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .cfg_i      (cfg_q),
    .target_i   (s_axis_tdata_i[W-1:0]),
    .measured_i (s_axis_tdata_i[3*W-1:2*W]),
    .pterm_o    (q_pterm),
    .acc_o      (q_acc)
  );

  dqpi_lane u_lane_d (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .cfg_i      (cfg_q),
    .target_i   (s_axis_tdata_i[2*W-1:W]),
    .measured_i (s_axis_tdata_i[4*W-1:3*W]),
    .pterm_o    (d_pterm),
    .acc_o      (d_acc)
  );

  // Merge: final output sum and clamp per lane, into the output register
  logic signed [W-1:0] q_volt;
  logic signed [W-1:0] d_volt;
  logic [2*W-1:0]      out_q;

  assign q_volt = dqpi_pkg::clamp_sym(
                    dqpi_pkg::sat33({q_pterm[W-1], q_pterm} + {q_acc[W-1], q_acc}),
                    cfg_q.out_limit);
  assign d_volt = dqpi_pkg::clamp_sym(
                    dqpi_pkg::sat33({d_pterm[W-1], d_pterm} + {d_acc[W-1], d_acc}),
                    cfg_q.out_limit);

  always_ff @(posedge clk_i) begin
    if (en.out_en) begin
      out_q <= {d_volt, q_volt};
    end
  end

  assign m_axis_tdata_o = out_q;

`ifndef NO_ASSERTIONS
  // Lane result registers only move when the integral stage advances
  a_acc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en.integ_en |=> $stable(q_acc) && $stable(d_acc))
    else $error("lane result changed without a stage advance");

  // Output register is only overwritten when empty or draining
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en.out_en |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("output register overwritten while holding a result");

  // A new result appears only after the output stage was loaded
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(en.out_en))
    else $error("output valid rose without a load");
`endif

endmodule
